// ===== rtl/core/pba_pkg.sv =====
`default_nettype none

package pba_pkg;

  localparam int FRAME_W   = 40;
  localparam int COUNT_W   = 13;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int WORD_W  = 8;
  localparam int WORD_LG = 3;

  localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(4096);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/pba_ram.sv =====
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/page_bitmap_allocator_core.sv =====
`default_nettype none

// Channel    Direction  Handshake          Payload
// request    in         start_i, busy_o    operation_i, page_count_i, want_dma_i, free_frame_i
// result     out        done_o             status_o, frame_o
// config     in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// After reset the bitmap is swept clear, one word of eight pages a cycle, with busy_o
// high. A successful allocate reads the bitmap words of the zone up to the run found, then
// rewrites each word of the run. A free that lies in range rewrites each bitmap word it
// touches. The bitmap RAM has one read port and one write port, one word a cycle each.
// done_o is a one-cycle strobe in the first idle cycle, and the receiver cannot stall it.

module page_bitmap_allocator_core
  import pba_pkg::*;
#(
  parameter int PAGES = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 operation_i,
  input  wire logic [COUNT_W-1:0]   page_count_i,
  input  wire logic                 want_dma_i,
  input  wire logic [FRAME_W-1:0]   free_frame_i,
  output logic                      done_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [FRAME_W-1:0]   frame_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FRAME_W-1:0]   cfg_wdata_i
);

  localparam int PW    = $clog2(PAGES + 1);
  localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW    = PW - WORD_LG;
  localparam int CW    = (PW > COUNT_W) ? PW : COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_PREP,
    S_CHECK,
    S_SETUP,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_e;

  state_e state_q;

  logic [FRAME_W-1:0] base_q;
  logic [COUNT_W-1:0] dma_q;
  logic [COUNT_W-1:0] total_q;

  logic               op_q;
  logic [COUNT_W-1:0] count_q;
  logic               want_dma_q;
  logic [FRAME_W-1:0] fframe_q;

  logic [FRAME_W:0]   diff_q;
  logic [PW-1:0]      s_q;
  logic [PW-1:0]      e_q;
  logic               scan_q;
  logic [XW-1:0]      issue_q;
  logic [XW-1:0]      last_q;
  logic               iss_on_q;
  logic               rv_q;
  logic [XW-1:0]      ridx_q;
  logic [COUNT_W-1:0] run_q;
  logic [PW-1:0]      cand_q;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [FRAME_W-1:0]  frame_q;

  logic [PW-1:0]      tot;
  logic [PW-1:0]      dmz;
  logic [FRAME_W:0]   fend;
  logic               free_ok;
  logic [PW-1:0]      kb;
  logic [WORD_W-1:0]  mask;
  logic [COUNT_W-1:0] run_n;
  logic [PW-1:0]      cand_n;
  logic               fnd_n;
  logic [PW-1:0]      elast;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  always_comb begin
    if (CW'(total_q) > CW'(PAGES)) begin
      tot = PW'(PAGES);
    end else begin
      tot = PW'(total_q);
    end
    if (CW'(dma_q) > CW'(tot)) begin
      dmz = tot;
    end else begin
      dmz = PW'(dma_q);
    end
  end

  assign fend    = {1'b0, diff_q[FRAME_W-1:0]} + (FRAME_W + 1)'(count_q);
  assign free_ok = !diff_q[FRAME_W] && (fend <= (FRAME_W + 1)'(tot));
  assign elast   = e_q - PW'(1);

  always_comb begin
    kb     = {ridx_q, {WORD_LG{1'b0}}};
    run_n  = run_q;
    cand_n = cand_q;
    fnd_n  = 1'b0;
    for (int j = 0; j < WORD_W; j++) begin
      mask[j] = ((kb + PW'(j)) >= s_q) && ((kb + PW'(j)) < e_q);
      if (!fnd_n) begin
        if (!mask[j] || ram_rdata[j]) begin
          run_n  = '0;
          cand_n = kb + PW'(j) + PW'(1);
        end else begin
          run_n = run_n + COUNT_W'(1);
          if (run_n == count_q) begin
            fnd_n = 1'b1;
          end
        end
      end
    end
  end

  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_UPDATE) && rv_q);
  assign ram_waddr = (state_q == S_CLEAR) ? AW'(issue_q) : AW'(ridx_q);
  assign ram_wdata = (state_q == S_CLEAR) ? '0 :
                     (op_q == OP_ALLOC) ? (ram_rdata | mask) : (ram_rdata & ~mask);

  pba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (AW'(issue_q)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      dma_q   <= '0;
      total_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  base_q  <= cfg_wdata_i;
        CFG_DMA:   dma_q   <= cfg_wdata_i[COUNT_W-1:0];
        CFG_TOTAL: total_q <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      issue_q  <= '0;
      iss_on_q <= 1'b0;
      rv_q     <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      frame_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          issue_q <= issue_q + XW'(1);
          if (issue_q == XW'(WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            op_q       <= operation_i;
            count_q    <= page_count_i;
            want_dma_q <= want_dma_i;
            fframe_q   <= free_frame_i;
            state_q    <= S_PREP;
          end
        end
        S_PREP: begin
          if (op_q == OP_ALLOC) begin
            s_q     <= want_dma_q ? '0 : dmz;
            e_q     <= want_dma_q ? dmz : tot;
            scan_q  <= 1'b1;
            state_q <= S_SETUP;
          end else begin
            diff_q  <= {1'b0, fframe_q} - {1'b0, base_q};
            scan_q  <= 1'b0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (free_ok) begin
            s_q     <= diff_q[PW-1:0];
            e_q     <= fend[PW-1:0];
            state_q <= S_SETUP;
          end else begin
            status_q <= ST_RANGE;
            state_q  <= S_FINISH;
          end
        end
        S_SETUP: begin
          rv_q <= 1'b0;
          if ((scan_q && (count_q == '0)) || (s_q >= e_q)) begin
            status_q <= (op_q == OP_ALLOC) ? ST_NOSPACE : ST_OK;
            state_q  <= S_FINISH;
          end else begin
            issue_q  <= s_q[PW-1:WORD_LG];
            last_q   <= elast[PW-1:WORD_LG];
            iss_on_q <= 1'b1;
            run_q    <= '0;
            cand_q   <= s_q;
            state_q  <= scan_q ? S_SCAN : S_UPDATE;
          end
        end
        S_SCAN, S_UPDATE: begin
          rv_q   <= iss_on_q;
          ridx_q <= issue_q;
          if (iss_on_q) begin
            issue_q <= issue_q + XW'(1);
            if (issue_q == last_q) begin
              iss_on_q <= 1'b0;
            end
          end
          if (rv_q) begin
            if (state_q == S_SCAN) begin
              run_q  <= run_n;
              cand_q <= cand_n;
              if (fnd_n) begin
                s_q     <= cand_n;
                e_q     <= cand_n + PW'(count_q);
                scan_q  <= 1'b0;
                state_q <= S_SETUP;
              end else if (ridx_q == last_q) begin
                status_q <= ST_NOSPACE;
                state_q  <= S_FINISH;
              end
            end else if (ridx_q == last_q) begin
              status_q <= ST_OK;
              state_q  <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          done_q <= 1'b1;
          if ((op_q == OP_ALLOC) && (status_q == ST_OK)) begin
            frame_q <= base_q + FRAME_W'(s_q);
          end else begin
            frame_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign frame_o  = frame_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (frame_o == '0))
    else $error("failed request returned a non-zero frame");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_OK) || (status_o == ST_NOSPACE) || (status_o == ST_RANGE)))
    else $error("undefined status code");

endmodule

`default_nettype wire

// ===== verif/tb_page_bitmap_allocator_core.sv =====
`default_nettype none

module tb_page_bitmap_allocator_core;
  import pba_pkg::*;

  localparam int PAGES      = 4096;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN      = 16;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } alloc_result_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
  } page_run_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic                 op;
    logic [COUNT_W-1:0]   count;
    logic                 want_dma;
    logic [FRAME_W-1:0]   value;
    bit                   typed;
    alloc_result_t        result;
  } stim_row_t;

  typedef struct {
    logic [FRAME_W-1:0] base;
    logic [COUNT_W-1:0] dma;
    logic [COUNT_W-1:0] total;
    int unsigned        idle_pct;
    int unsigned        items;
  } phase_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 start_i      = 1'b0;
  logic                 busy_o;
  logic                 operation_i  = OP_ALLOC;
  logic [COUNT_W-1:0]   page_count_i = '0;
  logic                 want_dma_i   = 1'b0;
  logic [FRAME_W-1:0]   free_frame_i = '0;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [FRAME_W-1:0]   frame_o;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = CFG_BASE;
  logic [FRAME_W-1:0]   cfg_wdata_i  = '0;

  page_bitmap_allocator_core #(
    .PAGES(PAGES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .page_count_i(page_count_i),
    .want_dma_i  (want_dma_i),
    .free_frame_i(free_frame_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .frame_o     (frame_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bit                 page_used [PAGES];
  logic [FRAME_W-1:0] base_frame = '0;
  logic [COUNT_W-1:0] dma_cfg    = '0;
  logic [COUNT_W-1:0] total_cfg  = TOTAL_RESET;
  alloc_result_t      pending_results[$];
  page_run_t          live_runs[$];
  stim_row_t          directed_rows[$];
  int unsigned        mismatches  = 0;
  int unsigned        idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_pages();
    return (total_cfg < PAGES) ? int'(total_cfg) : PAGES;
  endfunction

  function automatic int unsigned dma_zone_pages();
    return (dma_cfg < usable_pages()) ? int'(dma_cfg) : usable_pages();
  endfunction

  function automatic alloc_result_t predict_result(logic op, logic [COUNT_W-1:0] count,
                                                   logic want_dma,
                                                   logic [FRAME_W-1:0] first_frame);
    alloc_result_t   res;
    int unsigned     lo, hi, run, k, p;
    longint unsigned off;
    bit              found;
    res.status = ST_OK;
    res.frame  = '0;
    if (op == OP_ALLOC) begin
      lo    = want_dma ? 0 : dma_zone_pages();
      hi    = want_dma ? dma_zone_pages() : usable_pages();
      run   = 0;
      found = 1'b0;
      k     = lo;
      if (count != 0) begin
        while (k < hi && !found) begin
          if (page_used[k]) begin
            run = 0;
          end else begin
            run++;
            found = (run == count);
          end
          k++;
        end
      end
      if (!found) begin
        res.status = ST_NOSPACE;
      end else begin
        for (p = k - count; p < k; p++) page_used[p] = 1'b1;
        res.frame = base_frame + FRAME_W'(k - count);
      end
    end else begin
      off = 64'(first_frame) - 64'(base_frame);
      if (first_frame < base_frame || off + 64'(count) > 64'(usable_pages())) begin
        res.status = ST_RANGE;
      end else begin
        for (p = int'(off); p < off + count; p++) page_used[p] = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic add_req(logic op, int unsigned count, logic want_dma,
                         logic [FRAME_W-1:0] value, bit typed,
                         logic [STATUS_W-1:0] status, logic [FRAME_W-1:0] frame);
    stim_row_t row;
    row.is_cfg        = 1'b0;
    row.idx           = CFG_BASE;
    row.op            = op;
    row.count         = COUNT_W'(count);
    row.want_dma      = want_dma;
    row.value         = value;
    row.typed         = typed;
    row.result.status = status;
    row.result.frame  = frame;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] value);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    directed_rows.push_back(row);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_BASE: begin
        base_frame = data;
      end
      CFG_DMA: begin
        dma_cfg = data[COUNT_W-1:0];
      end
      CFG_TOTAL: begin
        total_cfg = data[COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_request(logic op, logic [COUNT_W-1:0] count, logic want_dma,
                              logic [FRAME_W-1:0] first_frame, int unsigned idle_pct,
                              bit typed, alloc_result_t typed_result);
    alloc_result_t res;
    page_run_t     run;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    page_count_i <= count;
    want_dma_i   <= want_dma;
    free_frame_i <= first_frame;
    do @(posedge clk_i); while (busy_o);
    res = predict_result(op, count, want_dma, first_frame);
    if (op == OP_ALLOC && res.status == ST_OK) begin
      run.frame = res.frame;
      run.count = count;
      live_runs.push_back(run);
    end
    pending_results.push_back(typed ? typed_result : res);
  endtask

  task automatic send_random(int unsigned idle_pct);
    logic               op, want_dma;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] first_frame;
    int unsigned        pick, zone, slot, r;
    page_run_t          run;
    pick        = $urandom_range(0, 99);
    want_dma    = 1'($urandom_range(0, 1));
    first_frame = FRAME_W'({$urandom(), $urandom()});
    count       = COUNT_W'($urandom());
    op          = OP_FREE;
    if (pick < 50) begin
      op   = OP_ALLOC;
      zone = want_dma ? dma_zone_pages() : usable_pages() - dma_zone_pages();
      r    = $urandom_range(0, 99);
      if (r < 4) count = '0;
      else if (r < 64) count = COUNT_W'($urandom_range(1, 8));
      else if (r < 84) count = COUNT_W'($urandom_range(9, 64));
      else if (r < 96) count = COUNT_W'($urandom_range(1, zone + 1));
    end else if (pick < 85 && live_runs.size() != 0) begin
      slot = $urandom_range(0, live_runs.size() - 1);
      run  = live_runs[slot];
      live_runs.delete(slot);
      count       = run.count;
      first_frame = run.frame;
    end else begin
      r = $urandom_range(0, 3);
      if (r != 3) count = COUNT_W'($urandom_range(0, 16));
      case (r)
        0: first_frame = base_frame + FRAME_W'($urandom_range(0, usable_pages()));
        1: first_frame = base_frame - FRAME_W'($urandom_range(1, 4));
        2: first_frame = base_frame + FRAME_W'(usable_pages()) - FRAME_W'(count)
                         + FRAME_W'($urandom_range(0, 1));
        default: begin
        end
      endcase
    end
    send_request(op, count, want_dma, first_frame, idle_pct, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d frame %h", status_o, frame_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || frame_o !== want.frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: expected status %0d frame %h, got status %0d frame %h",
                     want.status, want.frame, status_o, frame_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    phase_t      phases [NUM_PHASES];
    int unsigned ph;
    bit          prev_cfg;
    alloc_result_t typed_result;

    // Zones and sizes per phase, from the reset setting to an empty range and
    // DMA zones that exceed the usable total.
    phases[0] = '{40'd0, 13'd0, 13'd4096, 0, 200};
    phases[1] = '{FRAME_W'({$urandom(), $urandom()}), 13'd64, 13'd256, 85, 180};
    phases[2] = '{40'hFF_FFFF_FFFF, 13'd4096, 13'd4096, 27, 150};
    phases[3] = '{FRAME_W'({$urandom(), $urandom()}), 13'd8191, 13'd8191, 0, 150};
    phases[4] = '{40'd100, 13'd0, 13'd0, 85, 40};
    phases[5] = '{FRAME_W'({$urandom(), $urandom()}), 13'd32, 13'd128, 27, 180};
    phases[6] = '{FRAME_W'({$urandom(), $urandom()}), 13'd50, 13'd40, 0, 150};
    phases[7] = '{FRAME_W'({$urandom(), $urandom()}), 13'd1024, 13'd2048, 85, 150};

    add_req(OP_ALLOC, 1, 1'b0, '0, 1'b1, ST_OK, '0);
    add_req(OP_ALLOC, 0, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_ALLOC, 1, 1'b1, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_ALLOC, 4096, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_FREE, 1, 1'b0, '0, 1'b1, ST_OK, '0);
    add_req(OP_ALLOC, 4096, 1'b0, '0, 1'b1, ST_OK, '0);
    add_req(OP_ALLOC, 1, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_FREE, 4096, 1'b1, '0, 1'b1, ST_OK, '0);
    add_req(OP_FREE, 4096, 1'b0, 40'd1, 1'b1, ST_RANGE, '0);
    add_req(OP_FREE, 1, 1'b0, 40'hFF_FFFF_FFFF, 1'b1, ST_RANGE, '0);
    add_req(OP_ALLOC, 8191, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_FREE, 0, 1'b0, 40'd4096, 1'b1, ST_OK, '0);
    add_req(OP_FREE, 8191, 1'b0, 40'd4095, 1'b1, ST_RANGE, '0);
    add_cfg(CFG_BASE, 40'hFF_FFFF_FFFC);
    add_cfg(CFG_DMA, 40'd16);
    add_cfg(CFG_TOTAL, 40'd64);
    add_req(OP_ALLOC, 16, 1'b1, '0, 1'b1, ST_OK, 40'hFF_FFFF_FFFC);
    add_req(OP_ALLOC, 1, 1'b1, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_ALLOC, 48, 1'b0, '0, 1'b1, ST_OK, 40'h00_0000_000C);
    add_req(OP_ALLOC, 1, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_FREE, 16, 1'b0, 40'd4, 1'b1, ST_RANGE, '0);
    add_req(OP_FREE, 4, 1'b0, 40'hFF_FFFF_FFFC, 1'b1, ST_OK, '0);
    add_req(OP_FREE, 16, 1'b1, 40'hFF_FFFF_FFFE, 1'b0, ST_OK, '0);
    add_req(OP_ALLOC, 2, 1'b1, '0, 1'b1, ST_OK, 40'hFF_FFFF_FFFC);
    add_req(OP_ALLOC, 2, 1'b0, '0, 1'b0, ST_OK, '0);
    add_cfg(CFG_BASE, 40'd0);
    add_cfg(CFG_DMA, 40'd8191);
    add_cfg(CFG_TOTAL, 40'd8191);
    add_req(OP_ALLOC, 1, 1'b0, '0, 1'b1, ST_NOSPACE, '0);
    add_req(OP_ALLOC, 3, 1'b1, '0, 1'b0, ST_OK, '0);
    add_req(OP_FREE, 4096, 1'b0, '0, 1'b1, ST_OK, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    wait_idle();

    prev_cfg = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        if (prev_cfg) cfg_we_i <= 1'b0;
        typed_result = directed_rows[i].result;
        send_request(directed_rows[i].op, directed_rows[i].count, directed_rows[i].want_dma,
                     directed_rows[i].value, 0, directed_rows[i].typed, typed_result);
      end
      prev_cfg = directed_rows[i].is_cfg;
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_BASE, phases[ph].base);
      write_reg(CFG_DMA, FRAME_W'(phases[ph].dma));
      write_reg(CFG_TOTAL, FRAME_W'(phases[ph].total));
      cfg_we_i <= 1'b0;
      live_runs.delete();
      // A request that frees the whole usable range opens each phase.
      send_request(OP_FREE, COUNT_W'(usable_pages()), 1'b0, base_frame,
                   phases[ph].idle_pct, 1'b0, '0);
      repeat (phases[ph].items) send_random(phases[ph].idle_pct);
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== page_bitmap_allocator_core.f =====
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/page_bitmap_allocator_core.sv
verif/tb_page_bitmap_allocator_core.sv
